// ===== rtl/core/spb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sample pack-and-batch core: register indexes, item modes,
// sequencer states and fixed sizes. No dependencies.
package spb_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = 6;

    localparam logic [15:0] PACK_MAX = 16'hFFFF;

    localparam logic [1:0] REG_CHANNEL_ID   = 2'd0;
    localparam logic [1:0] REG_WIDE_MODE    = 2'd1;
    localparam logic [1:0] REG_OFFSET_VALUE = 2'd2;
    localparam logic [1:0] REG_SHIFT_AMOUNT = 2'd3;

    localparam logic MODE_COMMIT = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/core/sample_pack_and_batch_core.sv =====
`timescale 1ns / 1ps
// Top level of the sample pack-and-batch core: sample buffer, packer, APB
// registers and message read-out sequencer. Depends on spb_pkg.

// On a commit item the sample is packed (or kept raw in wide mode) and
// written to the 32-entry buffer memory. When the message fills, or a flush
// item arrives with samples pending, the input stalls, also through any
// output stall, while the buffer's registered read port is primed and then
// one result item per cycle, while the output is not stalled, is read from
// the single read port in order, the final one flagged last. A flush with
// nothing pending gives no result. Configuration is taken from the APB port
// at addresses 0, 4, 8 and 12 and must only change while the core is idle.
module sample_pack_and_batch_core #(
    parameter int NARROW_PER_MSG = 32,
    parameter int WIDE_PER_MSG   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_sample,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_channel,
    output logic        o_wide,
    output logic [5:0]  o_sample_count,
    output logic [4:0]  o_sample_index,
    output logic [31:0] o_value,
    output logic        o_last
);

    localparam int NarrowLimInt = (NARROW_PER_MSG > spb_pkg::BUF_DEPTH) ? spb_pkg::BUF_DEPTH :
                                  (NARROW_PER_MSG < 1) ? 1 : NARROW_PER_MSG;
    localparam int WideLimInt   = (WIDE_PER_MSG > spb_pkg::BUF_DEPTH) ? spb_pkg::BUF_DEPTH :
                                  (WIDE_PER_MSG < 1) ? 1 : WIDE_PER_MSG;
    localparam logic [spb_pkg::CNT_W-1:0] NarrowLim = spb_pkg::CNT_W'(NarrowLimInt);
    localparam logic [spb_pkg::CNT_W-1:0] WideLim   = spb_pkg::CNT_W'(WideLimInt);
    localparam logic [spb_pkg::CNT_W-1:0] FillMax   = spb_pkg::CNT_W'(spb_pkg::BUF_DEPTH - 1);

    logic [2:0]  r_channel_id;
    logic        r_wide_mode;
    logic [31:0] r_offset_value;
    logic [4:0]  r_shift_amount;

    spb_pkg::t_state r_state, n_state;
    logic [spb_pkg::CNT_W-1:0] r_fill, n_fill;
    logic [spb_pkg::CNT_W-1:0] r_count, n_count;
    logic [spb_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [spb_pkg::IDX_W-1:0] rd_addr;
    logic [spb_pkg::IDX_W-1:0] wr_addr;
    logic        wr_en;
    logic [31:0] wr_data;
    logic [31:0] r_rd_data;

    logic [31:0] r_buf [spb_pkg::BUF_DEPTH];

    logic        cfg_wr;
    logic        in_acc;
    logic        out_acc;
    logic [32:0] diff;
    logic [31:0] shifted;
    logic [15:0] packed16;
    logic [spb_pkg::CNT_W-1:0] fill_sat;
    logic [spb_pkg::CNT_W-1:0] fill_inc;
    logic [spb_pkg::CNT_W-1:0] limit;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_id   <= '0;
            r_wide_mode    <= 1'b0;
            r_offset_value <= '0;
            r_shift_amount <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                spb_pkg::REG_CHANNEL_ID:   r_channel_id   <= pwdata[2:0];
                spb_pkg::REG_WIDE_MODE:    r_wide_mode    <= pwdata[0];
                spb_pkg::REG_OFFSET_VALUE: r_offset_value <= pwdata;
                spb_pkg::REG_SHIFT_AMOUNT: r_shift_amount <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            spb_pkg::REG_CHANNEL_ID:   prdata = {29'd0, r_channel_id};
            spb_pkg::REG_WIDE_MODE:    prdata = {31'd0, r_wide_mode};
            spb_pkg::REG_OFFSET_VALUE: prdata = r_offset_value;
            spb_pkg::REG_SHIFT_AMOUNT: prdata = {27'd0, r_shift_amount};
            default:                   prdata = '0;
        endcase
    end

    // packer: floor at zero, shift, saturate
    always_comb begin
        diff     = {1'b0, i_sample} - {1'b0, r_offset_value};
        shifted  = diff[31:0] >> r_shift_amount;
        packed16 = (|shifted[31:16]) ? spb_pkg::PACK_MAX : shifted[15:0];
        if (diff[32]) begin
            packed16 = '0;
        end
        wr_data  = r_wide_mode ? i_sample : {16'd0, packed16};
    end

    assign in_acc   = i_valid & ~o_stall;
    assign out_acc  = o_valid & ~i_stall;
    assign fill_sat = (r_fill > FillMax) ? FillMax : r_fill;
    assign fill_inc = fill_sat + spb_pkg::CNT_W'(1);
    assign wr_addr  = fill_sat[spb_pkg::IDX_W-1:0];
    assign limit    = r_wide_mode ? WideLim : NarrowLim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spb_pkg::ST_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_count = r_count;
        n_idx   = r_idx;
        wr_en   = 1'b0;
        rd_addr = r_idx;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            spb_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                rd_addr = '0;
                if (in_acc) begin
                    n_idx = '0;
                    if (i_mode == spb_pkg::MODE_FLUSH) begin
                        if (r_fill != '0) begin
                            n_count = r_fill;
                            n_state = spb_pkg::ST_PRIME;
                        end
                    end else begin
                        wr_en  = 1'b1;
                        n_fill = fill_inc;
                        if (fill_inc >= limit) begin
                            n_count = fill_inc;
                            n_state = spb_pkg::ST_PRIME;
                        end
                    end
                end
            end
            spb_pkg::ST_PRIME: begin
                rd_addr = '0;
                n_state = spb_pkg::ST_EMIT;
            end
            spb_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                if (out_acc) begin
                    if (o_last) begin
                        n_fill  = '0;
                        n_state = spb_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + spb_pkg::IDX_W'(1);
                        rd_addr = n_idx;
                    end
                end
            end
            default: n_state = spb_pkg::ST_IDLE;
        endcase
    end

    // sample buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[wr_addr] <= wr_data;
        end
        r_rd_data <= r_buf[rd_addr];
    end

    assign o_channel      = r_channel_id;
    assign o_wide         = r_wide_mode;
    assign o_sample_count = r_count;
    assign o_sample_index = r_idx;
    assign o_value        = r_rd_data;
    assign o_last         = ({1'b0, r_idx} + spb_pkg::CNT_W'(1)) == r_count;

`ifndef SYNTHESIS
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_sample_index} < o_sample_count))
        else $error("sample index beyond message size");

    a_index_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=>
            (o_valid && o_sample_index == $past(o_sample_index) + 5'd1))
        else $error("message read-out skipped or ended early");

    a_no_intake_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted during message read-out");

    a_fill_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (r_fill == '0 && !o_valid))
        else $error("fill count not cleared after message");
`endif

endmodule

// ===== sim/spb_message_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sample pack-and-batch core: watches the APB port and both item
// channels, predicts each message and compares it result by result. Depends on spb_pkg.
module spb_message_checker #(
    parameter int NARROW_PER_MSG = 32,
    parameter int WIDE_PER_MSG   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [3:0]        i_paddr,
    input  logic [31:0]       i_pwdata,

    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_mode,
    input  logic [31:0]       i_sample,

    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        i_channel,
    input  logic              i_wide,
    input  logic [5:0]        i_sample_count,
    input  logic [4:0]        i_sample_index,
    input  logic [31:0]       i_value,
    input  logic              i_last,

    output int unsigned       o_fail_count,
    output int unsigned       o_pending
);

    typedef struct packed {
        logic [2:0]  channel;
        logic        wide;
        logic [5:0]  count;
        logic [4:0]  index;
        logic [31:0] value;
        logic        last;
    } t_result;

    t_result     awaited_results[$];
    logic [31:0] held_values [spb_pkg::BUF_DEPTH];
    int unsigned held_count = 0;
    int unsigned fail_tally = 0;
    int unsigned outstanding = 0;

    logic [2:0]  cfg_channel = '0;
    logic        cfg_wide    = 1'b0;
    logic [31:0] cfg_offset  = '0;
    logic [4:0]  cfg_shift   = '0;

    assign o_fail_count = fail_tally;
    assign o_pending    = outstanding;

    function automatic logic [31:0] pack_level(input logic [31:0] raw);
        logic [31:0] diff;
        if (raw < cfg_offset) return '0;
        diff = (raw - cfg_offset) >> cfg_shift;
        return (diff > {16'h0, spb_pkg::PACK_MAX}) ? {16'h0, spb_pkg::PACK_MAX} : diff;
    endfunction

    function automatic int unsigned message_size();
        int lim;
        lim = cfg_wide ? WIDE_PER_MSG : NARROW_PER_MSG;
        if (lim > spb_pkg::BUF_DEPTH) lim = spb_pkg::BUF_DEPTH;
        if (lim < 1) lim = 1;
        return lim;
    endfunction

    task automatic release_message();
        t_result r;
        for (int unsigned k = 0; k < held_count; k++) begin
            r.channel = cfg_channel;
            r.wide    = cfg_wide;
            r.count   = 6'(held_count);
            r.index   = 5'(k);
            r.value   = held_values[k];
            r.last    = (k + 1 == held_count);
            awaited_results.push_back(r);
        end
        held_count = 0;
    endtask

    task automatic absorb_item(input logic mode, input logic [31:0] raw);
        if (mode == spb_pkg::MODE_FLUSH) begin
            release_message();
        end else begin
            if (held_count >= spb_pkg::BUF_DEPTH) held_count = spb_pkg::BUF_DEPTH - 1;
            held_values[held_count] = cfg_wide ? raw : pack_level(raw);
            held_count++;
            if (held_count >= message_size()) release_message();
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            cfg_channel = '0;
            cfg_wide    = 1'b0;
            cfg_offset  = '0;
            cfg_shift   = '0;
            held_count  = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: value 0x%0h index %0d", i_value, i_sample_index);
                    fail_tally++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("channel", 32'(want.channel), 32'(i_channel));
                    check_field("wide", 32'(want.wide), 32'(i_wide));
                    check_field("sample_count", 32'(want.count), 32'(i_sample_count));
                    check_field("sample_index", 32'(want.index), 32'(i_sample_index));
                    check_field("value", want.value, i_value);
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    spb_pkg::REG_CHANNEL_ID:   cfg_channel = i_pwdata[2:0];
                    spb_pkg::REG_WIDE_MODE:    cfg_wide    = i_pwdata[0];
                    spb_pkg::REG_OFFSET_VALUE: cfg_offset  = i_pwdata;
                    spb_pkg::REG_SHIFT_AMOUNT: cfg_shift   = i_pwdata[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) absorb_item(i_mode, i_sample);
        end
        outstanding = awaited_results.size();
    end

endmodule

// ===== sim/tb_sample_pack_and_batch_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the sample pack-and-batch core: clock, reset, APB set-up and
// item stimulus with random idling. Depends on spb_pkg, the core and the checker.
module tb_sample_pack_and_batch_core;

    localparam int          NARROW_PER_MSG = 32;
    localparam int          WIDE_PER_MSG   = 16;
    localparam int unsigned QUIET_LIMIT    = 2000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        i_valid  = 1'b0;
    logic        o_stall;
    logic        i_mode   = 1'b0;
    logic [31:0] i_sample = '0;

    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_channel;
    logic        o_wide;
    logic [5:0]  o_sample_count;
    logic [4:0]  o_sample_index;
    logic [31:0] o_value;
    logic        o_last;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned send_gap_pct = 0;
    int unsigned recv_gap_pct = 0;
    int unsigned quiet_cycles = 0;
    logic [31:0] cur_offset   = '0;
    logic [4:0]  cur_shift    = '0;

    sample_pack_and_batch_core #(
        .NARROW_PER_MSG (NARROW_PER_MSG),
        .WIDE_PER_MSG   (WIDE_PER_MSG)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_channel      (o_channel),
        .o_wide         (o_wide),
        .o_sample_count (o_sample_count),
        .o_sample_index (o_sample_index),
        .o_value        (o_value),
        .o_last         (o_last)
    );

    spb_message_checker #(
        .NARROW_PER_MSG (NARROW_PER_MSG),
        .WIDE_PER_MSG   (WIDE_PER_MSG)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_mode         (i_mode),
        .i_sample       (i_sample),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_channel      (o_channel),
        .i_wide         (o_wide),
        .i_sample_count (o_sample_count),
        .i_sample_index (o_sample_index),
        .i_value        (o_value),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_gap_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("FAIL sample_pack_and_batch_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic program_core(input logic [2:0] ch, input logic wide,
                                input logic [31:0] off, input logic [4:0] sh);
        hold_until_drained();
        repeat (4) @(posedge i_clk);
        apb_write(spb_pkg::REG_CHANNEL_ID, {29'h0, ch});
        apb_write(spb_pkg::REG_WIDE_MODE, {31'h0, wide});
        apb_write(spb_pkg::REG_OFFSET_VALUE, off);
        apb_write(spb_pkg::REG_SHIFT_AMOUNT, {27'h0, sh});
        cur_offset = off;
        cur_shift  = sh;
    endtask

    task automatic offer_item(input logic mode, input logic [31:0] raw);
        if ($urandom_range(59) == 0) hold_until_drained();
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_mode   <= mode;
        i_sample <= raw;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return cur_offset - 32'($urandom_range(1, 16));
            3, 4:    return cur_offset + (32'($urandom_range(0, 'h1FFFF)) << cur_shift);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return 32'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    task automatic run_segment();
        int unsigned n;
        n = $urandom_range(28, 46);
        repeat (n) begin
            if ($urandom_range(15) == 0) offer_item(spb_pkg::MODE_FLUSH, $urandom());
            else offer_item(spb_pkg::MODE_COMMIT, pick_sample());
        end
    endtask

    initial begin : stimulus
        logic [31:0] corner_samples [6];
        int unsigned seg;
        corner_samples = '{32'h0, 32'hFF, 32'h100, 32'h1000F0, 32'h100100, 32'hFFFFFFFF};
        seg = 0;
        send_gap_pct = 14;
        recv_gap_pct <= 46;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: empty flush, then a short partial message
        offer_item(spb_pkg::MODE_FLUSH, 32'hFFFFFFFF);
        offer_item(spb_pkg::MODE_COMMIT, 32'hFFFFFFFF);
        offer_item(spb_pkg::MODE_COMMIT, 32'h0);
        offer_item(spb_pkg::MODE_FLUSH, 32'h0);

        // narrow with pending samples, then switch to wide mid-message
        program_core(3'd5, 1'b0, 32'h100, 5'd4);
        foreach (corner_samples[i]) offer_item(spb_pkg::MODE_COMMIT, corner_samples[i]);
        repeat (11) offer_item(spb_pkg::MODE_COMMIT, pick_sample());
        program_core(3'd7, 1'b1, 32'hFFFFFFFF, 5'd31);
        offer_item(spb_pkg::MODE_COMMIT, 32'hFFFFFFFF);
        offer_item(spb_pkg::MODE_FLUSH, $urandom());

        for (int ph = 0; ph < 3; ph++) begin
            send_gap_pct = (ph == 0) ? 14 : (ph == 1) ? 46 : 0;
            recv_gap_pct <= (ph == 0) ? 46 : (ph == 1) ? 14 : 0;
            repeat (4) begin
                case (seg)
                    0:       program_core(3'($urandom_range(7)), 1'b0, '0, 5'd0);
                    1:       program_core(3'($urandom_range(7)), 1'b0, '1, 5'd31);
                    2:       program_core(3'd0, 1'b1, pick_offset(), 5'($urandom_range(31)));
                    default: program_core(3'($urandom_range(7)), 1'($urandom_range(1)),
                                          pick_offset(), 5'($urandom_range(31)));
                endcase
                run_segment();
                seg++;
            end
        end

        hold_until_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS sample_pack_and_batch_core");
        end else begin
            $display("FAIL sample_pack_and_batch_core");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/spb_pkg.sv
rtl/core/sample_pack_and_batch_core.sv
sim/spb_message_checker.sv
sim/tb_sample_pack_and_batch_core.sv
